// File: sv/mcoc_pkg.sv
// Package for the matrix chain order cost block.
// Holds shared sizes, the controller command and status structs and the state type.
package mcoc_pkg;
    localparam int MAX_MATRICES_DEF = 32;
    localparam int DIM_BITS_DEF     = 10;
    localparam int COST_BITS        = 35;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_ACC   = 7'b0010000,
        ST_WR    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;     // store one matrix shape
        logic init;     // begin a table fill
        logic rd;       // issue table and shape reads for current k
        logic mul;      // form the split term
        logic acc;      // fold the candidate into the running best
        logic wr;       // write the best cost for cell (i, j)
        logic done;     // emit result
    } t_cmd;

    typedef struct packed {
        logic k_last;   // k reached j-1
        logic i_last;   // last i for this length
        logic len_last; // length reached n
        logic single;   // chain has at most one matrix
    } t_stat;
endpackage

// File: sv/mcoc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No package dependency.
module mcoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/mcoc_ctrl.sv
// Controller state machine for the matrix chain order cost block.
// Depends on mcoc_pkg for the state, command and status types.
module mcoc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last,
    input  mcoc_pkg::t_stat i_stat,
    output mcoc_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import mcoc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state = i_stat.single ? ST_DONE : ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_stat.k_last ? ST_WR : ST_RD;
            end
            ST_WR: begin
                o_cmd.wr = 1'b1;
                n_state = (i_stat.i_last && i_stat.len_last) ? ST_DONE : ST_RD;
            end
            ST_DONE: begin
                o_cmd.done = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

// File: sv/mcoc_dp.sv
// Datapath: shape stores, cost table RAM, split multiplier and compare.
// Depends on mcoc_pkg and mcoc_ram.
module mcoc_dp #(
    parameter int MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS     = mcoc_pkg::DIM_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mcoc_pkg::t_cmd                  i_cmd,
    input  logic [9:0]                      i_matrix_rows,
    input  logic [9:0]                      i_matrix_cols,
    output mcoc_pkg::t_stat                 o_stat,
    output logic [mcoc_pkg::COST_BITS-1:0]  o_min_cost,
    output logic                            o_count_exceeded,
    output logic                            o_valid
);
    import mcoc_pkg::*;

    localparam int IW = $clog2(MAX_MATRICES);
    localparam int CW = $clog2(MAX_MATRICES + 1);
    localparam int AW = 2 * IW;
    localparam int PW = 3 * DIM_BITS;

    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [DIM_BITS-1:0] r_rows [MAX_MATRICES];
    logic [DIM_BITS-1:0] r_cols [MAX_MATRICES];
    logic [IW-1:0]       r_i, r_k, r_j;
    logic [CW-1:0]       r_len;
    logic [COST_BITS-1:0] r_best, r_term, r_cost, r_res;
    logic                r_have, r_ovf_res, r_valid;
    logic [PW-1:0]       r_prod;
    logic [PW-1:0]       full_term;
    logic [COST_BITS-1:0] left_cost, right_cost, rd_left, rd_right;
    logic [COST_BITS:0]  sum1, sum2;
    logic [COST_BITS-1:0] cand;
    logic [CW-1:0]       i_end;

    // Cost table: two RAM copies give two reads a cycle; zero on diagonal.
    logic                r_diag_l, r_diag_r;
    logic [AW-1:0]       raddr_l, raddr_r, waddr;
    logic [IW-1:0]       k1;

    assign k1      = r_k + IW'(1);
    assign raddr_l = {r_i, r_k};
    assign raddr_r = {k1, r_j};
    assign waddr   = {r_i, r_j};

    mcoc_ram #(.WIDTH(COST_BITS), .DEPTH(1 << AW)) u_cost_l (
        .i_clk(i_clk), .i_we(i_cmd.wr), .i_waddr(waddr), .i_wdata(r_best),
        .i_raddr(raddr_l), .o_rdata(rd_left));
    mcoc_ram #(.WIDTH(COST_BITS), .DEPTH(1 << AW)) u_cost_r (
        .i_clk(i_clk), .i_we(i_cmd.wr), .i_waddr(waddr), .i_wdata(r_best),
        .i_raddr(raddr_r), .o_rdata(rd_right));

    assign left_cost  = r_diag_l ? '0 : rd_left;
    assign right_cost = r_diag_r ? '0 : rd_right;

    assign sum1 = {1'b0, left_cost} + {1'b0, right_cost};
    assign sum2 = {1'b0, (sum1[COST_BITS] ? COST_MAX : sum1[COST_BITS-1:0])}
                  + {1'b0, r_term};
    assign cand = sum2[COST_BITS] ? COST_MAX : sum2[COST_BITS-1:0];

    assign full_term = r_prod * PW'(r_cols[r_j]);

    assign i_end = r_count - r_len;

    assign o_stat.k_last   = (r_k + IW'(1) == r_j);
    assign o_stat.i_last   = (CW'(r_i) == i_end);
    assign o_stat.len_last = (r_len == r_count);
    assign o_stat.single   = (r_count <= CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.done;
            if (i_cmd.load) begin
                if (r_count < CW'(MAX_MATRICES)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CW'(MAX_MATRICES)) begin
            r_rows[r_count[IW-1:0]] <= DIM_BITS'(i_matrix_rows);
            r_cols[r_count[IW-1:0]] <= DIM_BITS'(i_matrix_cols);
        end
        if (i_cmd.init) begin
            r_len  <= CW'(2);
            r_i    <= '0;
            r_k    <= '0;
            r_j    <= IW'(1);
            r_have <= 1'b0;
            r_cost <= '0;
        end
        if (i_cmd.rd) begin
            r_diag_l <= (r_i == r_k);
            r_diag_r <= (k1 == r_j);
            r_prod   <= PW'(r_rows[r_i]) * PW'(r_cols[r_k]);
        end
        if (i_cmd.mul) begin
            // clamp the split term to the cost range
            r_term <= (full_term > PW'(COST_MAX)) ? COST_MAX : COST_BITS'(full_term);
        end
        if (i_cmd.acc) begin
            if (!r_have || r_best >= cand) begin
                r_best <= cand;
            end
            r_have <= 1'b1;
            r_k    <= r_k + IW'(1);
        end
        if (i_cmd.wr) begin
            r_cost <= r_best;
            r_have <= 1'b0;
            if (o_stat.i_last) begin
                r_len <= r_len + CW'(1);
                r_i   <= '0;
                r_k   <= '0;
                r_j   <= IW'(r_len);
            end else begin
                r_i <= r_i + IW'(1);
                r_k <= r_i + IW'(1);
                r_j <= r_j + IW'(1);
            end
        end
        if (i_cmd.done) begin
            r_res     <= o_stat.single ? '0 : r_cost;
            r_ovf_res <= r_ovf;
        end
    end

    assign o_min_cost       = r_res;
    assign o_count_exceeded = r_ovf_res;
    assign o_valid          = r_valid;
endmodule

// File: sv/matrix_chain_order_cost.sv
// Top level of the matrix chain order cost block.
// Depends on mcoc_pkg, mcoc_ctrl, mcoc_dp and mcoc_ram.
//
//  channel | handshake        | payload
//  input   | start / busy     | i_matrix_rows, i_matrix_cols, i_last_matrix
//  result  | o_done strobe    | o_min_cost, o_count_exceeded
//
// A matrix that does not close the chain is stored while the block stays idle. The
// closing item starts the table fill: each split candidate passes through the read,
// multiply and accumulate states of the shared multiply and compare unit, each table
// cell is written in the write state, with an init state to start and a done state to
// finish; o_done is high in the first cycle with busy low.
// Reset is synchronous and active low and empties the chain.
// The result strobe lasts one cycle; the receiver cannot stall it.
module matrix_chain_order_cost #(
    parameter int MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS     = mcoc_pkg::DIM_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [9:0]                     i_matrix_rows,
    input  logic [9:0]                     i_matrix_cols,
    input  logic                           i_last_matrix,
    output logic                           o_done,
    output logic [mcoc_pkg::COST_BITS-1:0] o_min_cost,
    output logic                           o_count_exceeded
);
    import mcoc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mcoc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_last(i_last_matrix), .i_stat(stat), .o_cmd(cmd), .o_busy(busy));

    mcoc_dp #(.MAX_MATRICES(MAX_MATRICES), .DIM_BITS(DIM_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_matrix_rows(i_matrix_rows), .i_matrix_cols(i_matrix_cols),
        .o_stat(stat), .o_min_cost(o_min_cost),
        .o_count_exceeded(o_count_exceeded), .o_valid(o_done));
endmodule

// File: tb/sv/tb_matrix_chain_order_cost.sv
// Testbench for matrix_chain_order_cost: drives matrix chains through the
// start/busy handshake and checks each chain's least cost on the done strobe.
// Depends on mcoc_pkg and the matrix_chain_order_cost RTL.
module tb_matrix_chain_order_cost;
    timeunit 1ns;
    timeprecision 1ps;
    import mcoc_pkg::*;

    localparam int NMAX      = MAX_MATRICES_DEF;
    localparam int WDOG_MAX  = 100000;
    localparam longint CMAX  = (longint'(1) << COST_BITS) - 1;

    typedef struct {
        logic [COST_BITS-1:0] cost;
        logic                 exceeded;
    } chain_result_t;

    typedef struct {
        logic [9:0]           rows;
        logic [9:0]           cols;
        logic                 last;
        logic                 typed;
        logic [COST_BITS-1:0] cost;
        logic                 exceeded;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [9:0]           i_matrix_rows = '0;
    logic [9:0]           i_matrix_cols = '0;
    logic                 i_last_matrix = 1'b0;
    logic                 o_done;
    logic [COST_BITS-1:0] o_min_cost;
    logic                 o_count_exceeded;

    logic [9:0]    shape_rows [NMAX];
    logic [9:0]    shape_cols [NMAX];
    int            shape_cnt = 0;
    logic          shape_ovf = 1'b0;
    chain_result_t pending_costs [$];
    int            errors = 0;
    int            wdog = 0;
    int            sender_idle_pct = 0;
    int            idle_pcts [4] = '{0, 58, 0, 27};
    dir_row_t      dir_tbl [$];

    matrix_chain_order_cost uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_matrix_rows(i_matrix_rows), .i_matrix_cols(i_matrix_cols),
        .i_last_matrix(i_last_matrix), .o_done(o_done),
        .o_min_cost(o_min_cost), .o_count_exceeded(o_count_exceeded)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat_sum(longint a, longint b);
        return (a + b > CMAX) ? CMAX : a + b;
    endfunction

    // Bottom-up least-cost table over the stored shapes.
    function automatic longint least_chain_cost(int n);
        longint best_cost [NMAX][NMAX];
        longint best, c, term;
        int j;
        if (n == 0) return 0;
        for (int i = 0; i < n; i++) best_cost[i][i] = 0;
        for (int len = 2; len <= n; len++) begin
            for (int i = 0; i + len <= n; i++) begin
                j = i + len - 1;
                best = CMAX;
                for (int k = i; k < j; k++) begin
                    term = longint'(shape_rows[i]) * shape_cols[k] * shape_cols[j];
                    if (term > CMAX) term = CMAX;
                    c = sat_sum(sat_sum(best_cost[i][k], best_cost[k+1][j]), term);
                    if (k == i || best >= c) best = c;
                end
                best_cost[i][j] = best;
            end
        end
        return best_cost[0][n-1];
    endfunction

    // Update the chain store for one accepted item; return 1 when it closes a chain.
    function automatic bit absorb_matrix(logic [9:0] r, logic [9:0] c, logic last,
                                         output chain_result_t res);
        if (shape_cnt < NMAX) begin
            shape_rows[shape_cnt] = r;
            shape_cols[shape_cnt] = c;
            shape_cnt++;
        end else begin
            shape_ovf = 1'b1;
        end
        if (!last) return 0;
        res.cost     = least_chain_cost(shape_cnt);
        res.exceeded = shape_ovf;
        shape_cnt = 0;
        shape_ovf = 1'b0;
        return 1;
    endfunction

    // Check results and count cycles with no handshake.
    always @(posedge i_clk) begin
        chain_result_t exp_res;
        if (i_rst_n && o_done) begin
            if (pending_costs.size() == 0) begin
                $error("unexpected result: min_cost %0d count_exceeded %0b",
                       o_min_cost, o_count_exceeded);
                errors++;
            end else begin
                exp_res = pending_costs.pop_front();
                if (o_min_cost !== exp_res.cost) begin
                    $error("min_cost: expected %0d, actual %0d", exp_res.cost, o_min_cost);
                    errors++;
                end
                if (o_count_exceeded !== exp_res.exceeded) begin
                    $error("count_exceeded: expected %0b, actual %0b",
                           exp_res.exceeded, o_count_exceeded);
                    errors++;
                end
            end
        end
        if (!i_rst_n || o_done || (start && !busy)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one item and hold it until accepted.
    task automatic send_matrix(logic [9:0] r, logic [9:0] c, logic last,
                               logic typed = 1'b0, chain_result_t typed_res = '{0, 0});
        chain_result_t res;
        int gap;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_matrix_rows <= r;
        i_matrix_cols <= c;
        i_last_matrix <= last;
        do @(posedge i_clk); while (busy);
        if (absorb_matrix(r, c, last, res))
            pending_costs.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [9:0] rand_dim();
        case ($urandom_range(9))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'd1023;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    task automatic drain_results();
        start <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(int r, int c, bit last, bit typed = 0, longint cost = 0,
                           bit exc = 0);
        dir_row_t row;
        row = '{10'(r), 10'(c), last, typed, COST_BITS'(cost), exc};
        dir_tbl.push_back(row);
    endtask

    initial begin
        int len;
        int item_cnt;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single matrix, extremes, zero dims, mismatched shapes, short chains
        add_row(5, 7, 1, 1, 0, 0);
        add_row(1023, 1023, 0);
        add_row(1023, 1023, 1, 1, 1070599167, 0);
        add_row(0, 5, 0);
        add_row(3, 0, 1, 1, 0, 0);
        add_row(10, 20, 0);
        add_row(20, 30, 0);
        add_row(30, 40, 1, 1, 18000, 0);
        add_row(1023, 1, 0);
        add_row(1, 1023, 0);
        add_row(682, 341, 0);
        add_row(341, 682, 1);
        add_row(1, 1, 1, 1, 0, 0);
        add_row(512, 255, 0);
        add_row(7, 512, 0);
        add_row(99, 3, 0);
        add_row(0, 0, 1);
        foreach (dir_tbl[n])
            send_matrix(dir_tbl[n].rows, dir_tbl[n].cols, dir_tbl[n].last,
                        dir_tbl[n].typed, '{dir_tbl[n].cost, dir_tbl[n].exceeded});
        drain_results();

        // sender idle percent per phase: none, heavy, none, light
        foreach (idle_pcts[p]) begin
            sender_idle_pct = idle_pcts[p];
            item_cnt = 0;
            while (item_cnt < 100) begin
                case ($urandom_range(19))
                    0:       len = (p == 1 || p == 3) ? $urandom_range(32, 35)
                                                      : $urandom_range(7, 12);
                    1, 2:    len = $urandom_range(7, 12);
                    default: len = $urandom_range(1, 6);
                endcase
                for (int m = 0; m < len; m++)
                    send_matrix(rand_dim(), rand_dim(), m == len - 1);
                item_cnt += len;
            end
            // hold off until every chain in flight has reported
            drain_results();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_costs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/mcoc_pkg.sv
sv/mcoc_ram.sv
sv/mcoc_ctrl.sv
sv/mcoc_dp.sv
sv/matrix_chain_order_cost.sv
tb/sv/tb_matrix_chain_order_cost.sv
